// File: rtl/sca_pkg.sv
`timescale 1ns / 1ps

package sca_pkg;

    // Fixed field widths of the transaction payloads
    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int SET_OUT_W  = 10;
    localparam int WAY_OUT_W  = 2;

    // Configuration port
    localparam int CFG_DATA_W  = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int WAYS_CFG_W  = 3;

    // Largest way count the ways_in_use register can express
    localparam int WAYS_CFG_MAX = 7;

    // Default geometry
    localparam int DEF_LOG_SETS = 10;
    localparam int DEF_WAYS     = 4;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_BITS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SET_INDEX_BITS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WAYS_IN_USE    = 2'd2;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] RST_OFFSET_BITS    = 4'd4;
    localparam logic [CFG_DATA_W-1:0] RST_SET_INDEX_BITS = 4'd10;
    localparam logic [WAYS_CFG_W-1:0] RST_WAYS_IN_USE    = 3'd4;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } lookup_state_t;

endpackage

// File: rtl/set_assoc_cache_lru_lookup_top.sv
`timescale 1ns / 1ps

// Channel  | Handshake           | Payload
// ---------+---------------------+-------------------------------------------
// in       | in_valid / in_stall | address[31:0]
// out      | out_valid/out_stall | hit, way[1:0], set_index[9:0], tag[31:0]
// cfg      | cfg_wr_en           | cfg_index[1:0], cfg_data[3:0]
//
// For each address, the accept edge launches the set read on the memory read
// port; the lookup state then updates the row and writes it back.
// After reset a clearing sweep writes every set row (2^LOG_SETS rows, 1024
// by default) with in_stall high; cfg writes are taken meanwhile.
// A finished result sits in the output register while the next address is
// accepted; the update waits only if that register is still occupied.

module set_assoc_cache_lru_lookup_top #(
    parameter int LOG_SETS = sca_pkg::DEF_LOG_SETS,
    parameter int WAYS     = sca_pkg::DEF_WAYS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [sca_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sca_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [sca_pkg::ADDR_W-1:0]        address,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic [sca_pkg::WAY_OUT_W-1:0]     way,
    output logic [sca_pkg::SET_OUT_W-1:0]     set_index,
    output logic [sca_pkg::TAG_W-1:0]         tag
);

    import sca_pkg::*;

    localparam int SET_W    = (LOG_SETS > 0) ? LOG_SETS : 1;
    localparam int NUM_ROWS = 1 << LOG_SETS;
    localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENTRY_W  = TAG_W + RANK_W + 1;
    localparam int ROW_W    = WAYS * ENTRY_W;
    localparam int WAYS_CAP = (WAYS < WAYS_CFG_MAX) ? WAYS : WAYS_CFG_MAX;
    localparam logic [SET_W-1:0]      LAST_ROW    = SET_W'(NUM_ROWS - 1);
    localparam logic [CFG_DATA_W-1:0] LOG_SETS_LIM = CFG_DATA_W'(LOG_SETS);

    lookup_state_t state_reg;
    lookup_state_t state_next;

    logic [SET_W-1:0]      clr_cnt_reg;
    logic [CFG_DATA_W-1:0] offset_bits_reg;
    logic [CFG_DATA_W-1:0] set_bits_reg;
    logic [WAYS_CFG_W-1:0] ways_reg;

    logic [SET_W-1:0]      set_reg;
    logic [SET_OUT_W-1:0]  set_out_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic [WAYS_CFG_W-1:0] n_reg;

    logic                  out_valid_reg;
    logic                  hit_reg;
    logic [WAY_OUT_W-1:0]  way_reg;
    logic [SET_OUT_W-1:0]  set_index_reg;
    logic [TAG_W-1:0]      tag_out_reg;

    logic                  in_acc;
    logic                  out_free;
    logic                  row_done;
    logic [CFG_DATA_W-1:0] ib;
    logic [ADDR_W-1:0]     shifted;
    logic [ADDR_W-1:0]     set_mask;
    logic [ADDR_W-1:0]     set_full;
    logic [4:0]            tag_shift;
    logic [TAG_W-1:0]      in_tag;
    logic [WAYS_CFG_W-1:0] n_eff;

    logic                  mem_we;
    logic [SET_W-1:0]      mem_waddr;
    logic [ROW_W-1:0]      mem_wdata;
    logic [ROW_W-1:0]      mem_rdata;

    logic [WAYS-1:0][ENTRY_W-1:0] row_old;
    logic [WAYS-1:0][ENTRY_W-1:0] row_new;
    logic                  lru_hit;
    logic [WAY_W-1:0]      lru_way;
    logic [31:0]           way_ext;

    // Split the incoming address into set index and tag
    always_comb
    begin
        ib        = (set_bits_reg > LOG_SETS_LIM) ? LOG_SETS_LIM : set_bits_reg;
        shifted   = address >> offset_bits_reg;
        set_mask  = (ADDR_W'(1) << ib) - ADDR_W'(1);
        set_full  = shifted & set_mask;
        tag_shift = {1'b0, offset_bits_reg} + {1'b0, ib};
        in_tag    = address >> tag_shift;
        if (ways_reg == '0)
        begin
            n_eff = WAYS_CFG_W'(1);
        end
        else if (ways_reg > WAYS_CFG_W'(WAYS_CAP))
        begin
            n_eff = WAYS_CFG_W'(WAYS_CAP);
        end
        else
        begin
            n_eff = ways_reg;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign in_acc   = in_valid && !in_stall;
    assign row_done = (clr_cnt_reg == LAST_ROW);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (row_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State outputs: input stall and memory write port
    always_comb
    begin
        in_stall  = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = set_reg;
        mem_wdata = row_new;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_LOOKUP:
            begin
                mem_we = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Advance the sequencer and the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR && !row_done)
            begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            end
        end
    end

    // Take configuration writes; drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= RST_OFFSET_BITS;
            set_bits_reg    <= RST_SET_INDEX_BITS;
            ways_reg        <= RST_WAYS_IN_USE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_OFFSET_BITS:    offset_bits_reg <= cfg_data;
                REG_SET_INDEX_BITS: set_bits_reg    <= cfg_data;
                REG_WAYS_IN_USE:    ways_reg        <= cfg_data[WAYS_CFG_W-1:0];
                default:            ways_reg        <= ways_reg;
            endcase
        end
    end

    // Hold the accepted transaction during the lookup
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            set_reg     <= set_full[SET_W-1:0];
            set_out_reg <= set_full[SET_OUT_W-1:0];
            tag_reg     <= in_tag;
            n_reg       <= n_eff;
        end
    end

    sca_mem #(
        .ADDR_BITS (SET_W),
        .DATA_W    (ROW_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (in_acc),
        .raddr (set_full[SET_W-1:0]),
        .rdata (mem_rdata)
    );

    assign row_old = mem_rdata;

    sca_lru #(
        .WAYS    (WAYS),
        .RANK_W  (RANK_W),
        .WAY_W   (WAY_W),
        .ENTRY_W (ENTRY_W)
    ) u_lru (
        .n       (n_reg),
        .tag     (tag_reg),
        .row_in  (row_old),
        .row_out (row_new),
        .hit     (lru_hit),
        .way     (lru_way)
    );

    assign way_ext = 32'(lru_way);

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_LOOKUP && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOOKUP && out_free)
        begin
            hit_reg       <= lru_hit;
            way_reg       <= way_ext[WAY_OUT_W-1:0];
            set_index_reg <= set_out_reg;
            tag_out_reg   <= tag_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign way       = way_reg;
    assign set_index = set_index_reg;
    assign tag       = tag_out_reg;

    // A new result appears only right after a lookup cycle
    a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_LOOKUP))
        else $error("result appeared without a lookup");

    // An accepted transaction is looked up in the next cycle
    a_accept_then_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == ST_LOOKUP)
        else $error("accepted transaction not looked up");

    // The selected way is always one of the ways in use
    a_way_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOKUP |-> int'(lru_way) < int'(n_reg))
        else $error("selected way beyond ways in use");

    // The set row is never written while a read may be launched
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg != ST_IDLE)
        else $error("memory written in idle");

endmodule

// File: rtl/sca_mem.sv
`timescale 1ns / 1ps

module sca_mem #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_W    = 140
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_W-1:0]    wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_W-1:0]    rdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    // Registered read port, held between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/sca_lru.sv
`timescale 1ns / 1ps

module sca_lru #(
    parameter int WAYS    = 4,
    parameter int RANK_W  = 2,
    parameter int WAY_W   = 2,
    parameter int ENTRY_W = 35
) (
    input  logic [sca_pkg::WAYS_CFG_W-1:0]  n,
    input  logic [sca_pkg::TAG_W-1:0]       tag,
    input  logic [WAYS-1:0][ENTRY_W-1:0]    row_in,
    output logic [WAYS-1:0][ENTRY_W-1:0]    row_out,
    output logic                            hit,
    output logic [WAY_W-1:0]                way
);

    import sca_pkg::*;

    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);
    localparam logic [RANK_W:0]   FILL_LIMIT = (RANK_W + 1)'(WAYS);

    logic [WAYS-1:0]   in_use;
    logic [WAYS-1:0]   vld;
    logic [RANK_W-1:0] rk [WAYS];
    logic [TAG_W-1:0]  tg [WAYS];
    logic [WAYS-1:0]   match;
    logic [WAYS-1:0]   empty;
    logic [WAYS-1:0]   victim;
    logic [WAYS-1:0]   pick;
    logic              found;
    logic [WAY_W-1:0]  sel_way;
    logic [RANK_W:0]   limit;

    // Unpack the row and classify every way
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            in_use[i] = (i < int'(n));
            vld[i]    = row_in[i][0];
            rk[i]     = row_in[i][RANK_W:1];
            tg[i]     = row_in[i][ENTRY_W-1:RANK_W+1];
            match[i]  = in_use[i] && vld[i] && (tg[i] == tag);
            empty[i]  = in_use[i] && !vld[i];
        end
    end

    // Mark the oldest in-use way, lowest index on a tie
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            victim[i] = in_use[i];
            for (int j = 0; j < WAYS; j++)
            begin
                if (in_use[j] && j < i && !(rk[j] < rk[i]))
                begin
                    victim[i] = 1'b0;
                end
                if (in_use[j] && j > i && !(rk[j] <= rk[i]))
                begin
                    victim[i] = 1'b0;
                end
            end
        end
    end

    // Choose the way: hit, then first empty way, then the victim
    always_comb
    begin
        hit   = |match;
        found = |empty;
        if (hit)
        begin
            pick = match;
        end
        else if (found)
        begin
            pick = empty;
        end
        else
        begin
            pick = victim;
        end
        sel_way = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (pick[i])
            begin
                sel_way = WAY_W'(i);
            end
        end
    end

    assign way = sel_way;

    // Age younger ways and install the selected way as most recent
    always_comb
    begin
        if (!hit && found)
        begin
            limit = FILL_LIMIT;
        end
        else
        begin
            limit = {1'b0, rk[sel_way]};
        end
        for (int i = 0; i < WAYS; i++)
        begin
            row_out[i] = row_in[i];
            if (WAY_W'(i) == sel_way)
            begin
                row_out[i] = {tag, {RANK_W{1'b0}}, 1'b1};
            end
            else if (in_use[i] && vld[i] && ({1'b0, rk[i]} < limit) && (rk[i] < RANK_MAX))
            begin
                row_out[i][RANK_W:1] = rk[i] + RANK_W'(1);
            end
        end
    end

endmodule

// File: tb/sv/lru_directory_checker.sv
`timescale 1ns / 1ps

module lru_directory_checker #(
    parameter int LOG_SETS = sca_pkg::DEF_LOG_SETS,
    parameter int WAYS     = sca_pkg::DEF_WAYS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [sca_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sca_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [sca_pkg::ADDR_W-1:0]      address,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic                            hit,
    input  logic [sca_pkg::WAY_OUT_W-1:0]   way,
    input  logic [sca_pkg::SET_OUT_W-1:0]   set_index,
    input  logic [sca_pkg::TAG_W-1:0]       tag,
    output int                              mismatch_count,
    output int                              outstanding,
    output int                              hits_seen,
    output int                              misses_seen
);
    import sca_pkg::*;

    localparam int NUM_SETS = 1 << LOG_SETS;
    localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic [SET_OUT_W-1:0] set_index;
        logic [TAG_W-1:0]     tag;
    } lookup_result_t;

    // Shadow copy of the directory and its registers
    logic [CFG_DATA_W-1:0] cfg_offset_bits;
    logic [CFG_DATA_W-1:0] cfg_set_bits;
    logic [WAYS_CFG_W-1:0] cfg_ways;
    logic [TAG_W-1:0]      line_tag   [NUM_SETS][WAYS];
    logic                  line_valid [NUM_SETS][WAYS];
    logic [RANK_W-1:0]     line_age   [NUM_SETS][WAYS];

    lookup_result_t pending_lookups[$];

    // Look up one address, update tags and LRU ranks, return what the block must report
    function automatic lookup_result_t access_directory(input logic [ADDR_W-1:0] a);
        lookup_result_t r;
        int unsigned    ib;
        int unsigned    n;
        int unsigned    s;
        int unsigned    w;
        int unsigned    limit;
        int unsigned    best;
        int unsigned    i;
        logic [TAG_W-1:0] t;
        logic           matched;
        logic           found;

        ib = (32'(cfg_set_bits) > LOG_SETS) ? LOG_SETS : 32'(cfg_set_bits);
        n  = (32'(cfg_ways) == 0) ? 1 :
             ((32'(cfg_ways) > WAYS) ? WAYS : 32'(cfg_ways));
        s  = (a >> cfg_offset_bits) & ((32'd1 << ib) - 32'd1);
        t  = a >> (32'(cfg_offset_bits) + ib);

        // lowest-numbered valid way holding the tag wins
        matched = 1'b0;
        w       = 0;
        for (i = 0; i < n; i++)
        begin
            if (!matched && line_valid[s][i] && line_tag[s][i] == t)
            begin
                matched = 1'b1;
                w       = i;
            end
        end

        if (matched)
        begin
            limit = 32'(line_age[s][w]);
        end
        else
        begin
            // fill the first empty way, else evict the oldest (lowest on a tie)
            found = 1'b0;
            for (i = 0; i < n; i++)
            begin
                if (!found && !line_valid[s][i])
                begin
                    found = 1'b1;
                    w     = i;
                end
            end
            if (found)
            begin
                limit = WAYS;
            end
            else
            begin
                best = 0;
                w    = 0;
                for (i = 0; i < n; i++)
                begin
                    if (32'(line_age[s][i]) > best)
                    begin
                        best = 32'(line_age[s][i]);
                        w    = i;
                    end
                end
                limit = best;
            end
        end

        // age every younger valid way, saturating, and make the chosen way newest
        for (i = 0; i < n; i++)
        begin
            if (i != w && line_valid[s][i] && 32'(line_age[s][i]) < limit &&
                32'(line_age[s][i]) < WAYS - 1)
                line_age[s][i] = line_age[s][i] + RANK_W'(1);
        end
        line_age[s][w] = '0;
        if (!matched)
        begin
            line_valid[s][w] = 1'b1;
            line_tag[s][w]   = t;
        end

        r.hit       = matched;
        r.way       = w[WAY_OUT_W-1:0];
        r.set_index = s[SET_OUT_W-1:0];
        r.tag       = t;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
        end
    endtask

    // Track configuration, predict accepted addresses, check accepted results
    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t exp_r;
        if (!rst_n)
        begin
            cfg_offset_bits = RST_OFFSET_BITS;
            cfg_set_bits    = RST_SET_INDEX_BITS;
            cfg_ways        = RST_WAYS_IN_USE;
            for (int s = 0; s < NUM_SETS; s++)
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    line_valid[s][w] = 1'b0;
                    line_age[s][w]   = '0;
                end
            end
            pending_lookups.delete();
            mismatch_count = 0;
            outstanding    = 0;
            hits_seen      = 0;
            misses_seen    = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_OFFSET_BITS:    cfg_offset_bits = cfg_data;
                    REG_SET_INDEX_BITS: cfg_set_bits    = cfg_data;
                    REG_WAYS_IN_USE:    cfg_ways        = cfg_data[WAYS_CFG_W-1:0];
                    default:            ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (pending_lookups.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t ns: unexpected result, expected none, actual hit=%0b way=%0d set=%0d tag=0x%0h",
                             $time, hit, way, set_index, tag);
                end
                else
                begin
                    exp_r = pending_lookups.pop_front();
                    compare_field("hit", 32'(exp_r.hit), 32'(hit));
                    compare_field("way", 32'(exp_r.way), 32'(way));
                    compare_field("set_index", 32'(exp_r.set_index), 32'(set_index));
                    compare_field("tag", exp_r.tag, tag);
                    if (hit)
                        hits_seen++;
                    else
                        misses_seen++;
                end
            end

            if (in_valid && !in_stall)
                pending_lookups.push_back(access_directory(address));

            outstanding = pending_lookups.size();
        end
    end

endmodule

// File: tb/sv/set_assoc_cache_lru_lookup_top_tb.sv
`timescale 1ns / 1ps

module set_assoc_cache_lru_lookup_top_tb;
    import sca_pkg::*;

    localparam int CLK_HALF         = 2;
    localparam int RESET_CYCLES     = 5;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES  = 200;
    localparam int ITEMS_PER_PHASE  = 110;
    localparam int NUM_PHASES       = 14;
    localparam int NUM_POOL_TAGS    = 6;
    localparam int NUM_POOL_SETS    = 3;
    localparam int RECENT_DEPTH     = 64;
    localparam int HOLD_OFF_PHASE   = 3;
    localparam int NUM_DIRECTED     = 18;

    // Index 3 decodes to no register
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    // Geometry per phase: offset bits, set index bits, ways data (raw register value)
    localparam logic [CFG_DATA_W-1:0] PHASE_OFFSET [NUM_PHASES] =
        '{4'd0, 4'd12, 4'd15, 4'd4, 4'd2, 4'd3, 4'd3, 4'd6, 4'd0, 4'd8, 4'd1, 4'd12, 4'd13, 4'd5};
    localparam logic [CFG_DATA_W-1:0] PHASE_SET_BITS [NUM_PHASES] =
        '{4'd0, 4'd10, 4'd15, 4'd10, 4'd3, 4'd2, 4'd2, 4'd1, 4'd10, 4'd4, 4'd5, 4'd0, 4'd11, 4'd6};
    localparam logic [CFG_DATA_W-1:0] PHASE_WAYS [NUM_PHASES] =
        '{4'd1, 4'd4, 4'd7, 4'd4, 4'd0, 4'd2, 4'd4, 4'd3, 4'd12, 4'd9, 4'd2, 4'd4, 4'd8, 4'd3};

    // Reset geometry: extremes, then five tags fighting over set 5, then bit patterns
    localparam logic [ADDR_W-1:0] DIRECTED [NUM_DIRECTED] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_000F, 32'hFFFF_FFF0,
        32'h0000_4050, 32'h0000_8050, 32'h0000_C050, 32'h0001_0050,
        32'h0000_4050, 32'h0001_4050, 32'h0000_C05F, 32'h0000_8050,
        32'h0001_0050, 32'h0001_4057, 32'h8000_0000, 32'h7FFF_FFFF,
        32'hAAAA_AAAA, 32'h5555_5555
    };

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic [ADDR_W-1:0]      address   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   hit;
    logic [WAY_OUT_W-1:0]   way;
    logic [SET_OUT_W-1:0]   set_index;
    logic [TAG_W-1:0]       tag;

    int mismatch_count;
    int outstanding;
    int hits_seen;
    int misses_seen;

    int          cycle_count      = 0;
    int          addresses_sent   = 0;
    int          register_writes  = 0;
    logic        no_idle          = 1'b0;
    logic        hold_off_req     = 1'b0;
    int unsigned cur_offset       = 32'(RST_OFFSET_BITS);
    int unsigned cur_index_bits   = 32'(RST_SET_INDEX_BITS);

    logic [TAG_W-1:0]  pool_tags [NUM_POOL_TAGS];
    int unsigned       pool_sets [NUM_POOL_SETS];
    logic [ADDR_W-1:0] recent_addrs[$];

    set_assoc_cache_lru_lookup_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .address   (address),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .way       (way),
        .set_index (set_index),
        .tag       (tag)
    );

    lru_directory_checker directory_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .address        (address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .way            (way),
        .set_index      (set_index),
        .tag            (tag),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .hits_seen      (hits_seen),
        .misses_seen    (misses_seen)
    );

    always #(CLK_HALF) clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, outstanding);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: random stall before each transaction, one long hold-off on request
    initial
    begin
        int gap;
        int hc;
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                for (hc = 0; hc < HOLD_OFF_CYCLES; hc++)
                    @(negedge clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    // Offer one address after a random gap and hold it until taken
    task automatic send_address(input logic [ADDR_W-1:0] a);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        address  <= a;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        addresses_sent++;
        recent_addrs.push_back(a);
        if (recent_addrs.size() > RECENT_DEPTH)
            void'(recent_addrs.pop_front());
    endtask

    // Stop offering and wait until every expected result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write every register, plus the unused index, on consecutive cycles
    task automatic set_config(input logic [CFG_DATA_W-1:0] ob,
                              input logic [CFG_DATA_W-1:0] sib,
                              input logic [CFG_DATA_W-1:0] wd);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_UNUSED;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(negedge clk);
        cfg_index <= REG_OFFSET_BITS;
        cfg_data  <= ob;
        @(negedge clk);
        cfg_index <= REG_SET_INDEX_BITS;
        cfg_data  <= sib;
        @(negedge clk);
        cfg_index <= REG_WAYS_IN_USE;
        cfg_data  <= wd;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cur_offset      = 32'(ob);
        cur_index_bits  = (32'(sib) > DEF_LOG_SETS) ? DEF_LOG_SETS : 32'(sib);
        register_writes += 4;
    endtask

    // Build an address from tag and set under the current geometry, random line offset
    function automatic logic [ADDR_W-1:0] compose_address(input logic [TAG_W-1:0] t,
                                                         input int unsigned s);
        logic [63:0] v;
        v = ({32'd0, t} << (cur_offset + cur_index_bits)) |
            (64'(s) << cur_offset) |
            (64'($urandom) & ((64'd1 << cur_offset) - 64'd1));
        return v[ADDR_W-1:0];
    endfunction

    // Pick a small working set so that sets fill, hit and evict
    task automatic refresh_pool();
        logic [63:0] tag_mask;
        int unsigned tag_bits;
        tag_bits = ADDR_W - cur_offset - cur_index_bits;
        tag_mask = (64'd1 << tag_bits) - 64'd1;
        for (int i = 0; i < NUM_POOL_TAGS; i++)
            pool_tags[i] = TAG_W'($urandom) & tag_mask[TAG_W-1:0];
        for (int i = 0; i < NUM_POOL_SETS; i++)
            pool_sets[i] = $urandom & ((32'd1 << cur_index_bits) - 32'd1);
    endtask

    // Mostly working-set traffic, some replays across geometries, some noise
    function automatic logic [ADDR_W-1:0] next_address();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            return compose_address(pool_tags[$urandom_range(0, NUM_POOL_TAGS - 1)],
                                   pool_sets[$urandom_range(0, NUM_POOL_SETS - 1)]);
        else if (pick < 88 && recent_addrs.size() != 0)
            return recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
        else
            return $urandom;
    endfunction

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // directed accesses under the reset geometry
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_address(DIRECTED[i]);

        // random phases, each under its own geometry, entries carried across
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            set_config(PHASE_OFFSET[p], PHASE_SET_BITS[p], PHASE_WAYS[p]);
            refresh_pool();
            no_idle = (p % 3 == 2);
            if (p == HOLD_OFF_PHASE)
            begin
                // back-to-back addresses against a stalled result side
                no_idle      = 1'b1;
                hold_off_req = 1'b1;
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_address(next_address());
        end

        drain_results();

        $display("Run covered %0d addresses over %0d geometries (%0d register writes)",
                 addresses_sent, NUM_PHASES + 1, register_writes);
        $display("Results checked: %0d hits, %0d misses", hits_seen, misses_seen);
        if (mismatch_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
